### design/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int COORD_W   = 16;
   localparam int BOX_W     = 4 * COORD_W;
   localparam int SCORE_W   = 16;
   localparam int THR_W     = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;
   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // one classified box on its way from the front to the back end
   typedef struct packed {
      logic [BOX_W-1:0]   box;
      logic [SCORE_W-1:0] score;
      logic               final_box;
      logic               drop;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_WRITE,
      ST_ORD_SCAN,
      ST_K_ORD,
      ST_K_ORDW,
      ST_K_BOX,
      ST_P_RUN,
      ST_FLUSH
   } state_type;

endpackage

### design/gbs_ram.sv
`timescale 1ns / 1ps
module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/gbs_front.sv
`timescale 1ns / 1ps
module gbs_front import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  item_valid,
   input  logic                  item_ready,
   output item_type              item
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             take;

   assign req_tready = item_ready;
   assign take       = req_tvalid && item_ready;
   assign item_valid = req_tvalid;

   // classify: mark boxes past capacity as dropped
   always_comb begin
      item.box       = req_tdata[BOX_W-1:0];
      item.score     = req_tdata[BOX_W +: SCORE_W];
      item.final_box = req_tlast;
      item.drop      = (count_ff == CNT_W'(MAX_BOXES));
   end

   // count stored boxes, restart on the frame's last box
   always_comb begin
      count_in = count_ff;
      if (take) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (!item.drop) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### design/gbs_queue.sv
`timescale 1ns / 1ps
module gbs_queue import gbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] used_ff;
   logic       push, pop;

   assign in_ready  = (used_ff != 2'd2);
   assign out_valid = (used_ff != 2'd0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // hold entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         used_ff <= used_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### design/gbs_back.sv
`timescale 1ns / 1ps
module gbs_back import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [THR_W-1:0]      csr_wr_data,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  item_type              item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam int STORE_W = BOX_W + SCORE_W;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int UNI_W   = PROD_W + 2;
   localparam int CMP_W   = UNI_W + THR_W + 1;

   state_type state_ff, state_in;

   logic [THR_W-1:0]   thr_ff;
   logic [CNT_W-1:0]   n_ff, i_ff, j_ff;
   logic               ovf_ff;
   logic [MAX_BOXES-1:0] sup_ff;
   logic [IDX_W-1:0]   acc_ff;
   logic [BOX_W-1:0]   cur_box_ff;
   logic [SCORE_W-1:0] cur_score_ff;
   logic               cur_final_ff;

   logic               s1_v_ff;
   logic [IDX_W-1:0]   s1_j_ff;

   logic               p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff, p5_v_ff;
   logic [IDX_W-1:0]   p1_j_ff, p2_j_ff, p3_j_ff, p4_j_ff, p5_j_ff;
   logic [BOX_W-1:0]   key_box_ff;
   logic [IDX_W-1:0]   key_idx_ff;

   logic signed [DIFF_W-1:0] p3_dx_ff, p3_dy_ff, p3_wa_ff, p3_ha_ff, p3_wb_ff, p3_hb_ff;
   logic                     p3_dis_ff, p4_dis_ff, p5_dis_ff;
   logic signed [PROD_W-1:0] p4_inter_ff, p4_aa_ff, p4_ab_ff, p5_inter_ff;
   logic signed [UNI_W-1:0]  p5_uni_ff;
   logic signed [CMP_W-1:0]  cmp_lhs, cmp_rhs;

   logic               pend_v_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic [STORE_W-1:0] pend_data_ff;

   logic                  rsp_v_ff, rsp_v_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff, rsp_user_ff;
   logic                  out_free;

   // memory ports
   logic               st_we, rk_we, od_we;
   logic [IDX_W-1:0]   st_wa, rk_wa, od_wa, st_ra, rk_ra, od_ra;
   logic [STORE_W-1:0] st_wd, st_rd;
   logic [IDX_W-1:0]   rk_wd, rk_rd, od_wd, od_rd;

   logic issue_ok, pipe_busy, pop;

   gbs_ram #(.WIDTH(STORE_W), .DEPTH(MAX_BOXES)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd));
   gbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_rank (
      .clock(clock), .wr_en(rk_we), .wr_addr(rk_wa), .wr_data(rk_wd),
      .rd_addr(rk_ra), .rd_data(rk_rd));
   gbs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BOXES)) u_order (
      .clock(clock), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
      .rd_addr(od_ra), .rd_data(od_rd));

   assign out_free  = !rsp_v_ff || rsp_tready;
   assign issue_ok  = (j_ff < n_ff);
   assign pipe_busy = p1_v_ff || p2_v_ff || p3_v_ff || p4_v_ff || p5_v_ff;
   assign pop       = (state_ff == ST_IDLE) && item_valid;
   assign item_ready = (state_ff == ST_IDLE);

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.drop) state_in = item.final_box ? ST_ORD_SCAN : ST_IDLE;
               else           state_in = ST_INS_SCAN;
            end
         end
         ST_INS_SCAN:  if (!issue_ok && !s1_v_ff) state_in = ST_INS_WRITE;
         ST_INS_WRITE: state_in = cur_final_ff ? ST_ORD_SCAN : ST_IDLE;
         ST_ORD_SCAN:  if (!issue_ok && !s1_v_ff) state_in = ST_K_ORD;
         ST_K_ORD: begin
            if (i_ff == n_ff)                   state_in = ST_FLUSH;
            else if (!sup_ff[i_ff[IDX_W-1:0]])  state_in = ST_K_ORDW;
         end
         ST_K_ORDW: state_in = ST_K_BOX;
         ST_K_BOX:  if (out_free) state_in = ST_P_RUN;
         ST_P_RUN:  if (!issue_ok && !pipe_busy) state_in = ST_K_ORD;
         ST_FLUSH:  if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      st_we = 1'b0;
      st_wa = n_ff[IDX_W-1:0];
      st_wd = {cur_score_ff, cur_box_ff};
      rk_we = 1'b0;
      rk_wa = n_ff[IDX_W-1:0];
      rk_wd = acc_ff;
      od_we = 1'b0;
      od_wa = rk_rd;
      od_wd = s1_j_ff;
      st_ra = j_ff[IDX_W-1:0];
      rk_ra = j_ff[IDX_W-1:0];
      od_ra = j_ff[IDX_W-1:0];
      case (state_ff)
         ST_INS_SCAN: begin
            if (s1_v_ff && (st_rd[BOX_W +: SCORE_W] < cur_score_ff)) begin
               rk_we = 1'b1;
               rk_wa = s1_j_ff;
               rk_wd = rk_rd + 1'b1;
            end
         end
         ST_INS_WRITE: begin
            st_we = 1'b1;
            rk_we = 1'b1;
         end
         ST_ORD_SCAN: od_we = s1_v_ff;
         ST_K_ORD:    od_ra = i_ff[IDX_W-1:0];
         ST_K_ORDW:   st_ra = od_rd;
         ST_K_BOX:    st_ra = key_idx_ff;
         ST_P_RUN:    st_ra = od_rd;
         default: ;
      endcase
   end

   // overlap test operands at full product width
   always_comb begin
      cmp_lhs = {{(CMP_W-PROD_W-16){p5_inter_ff[PROD_W-1]}}, p5_inter_ff, 16'd0};
      cmp_rhs = $signed({1'b0, thr_ff}) * p5_uni_ff;
   end

   // result valid: drop on acceptance, raise on release of a kept box
   always_comb begin
      rsp_v_in = rsp_v_ff && !rsp_tready;
      if (out_free && (((state_ff == ST_K_BOX) && pend_v_ff) || (state_ff == ST_FLUSH))) begin
         rsp_v_in = 1'b1;
      end
   end

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         n_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         ovf_ff    <= 1'b0;
         sup_ff    <= '0;
         s1_v_ff   <= 1'b0;
         p1_v_ff   <= 1'b0;
         p2_v_ff   <= 1'b0;
         p3_v_ff   <= 1'b0;
         p4_v_ff   <= 1'b0;
         p5_v_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
         s1_v_ff  <= ((state_ff == ST_INS_SCAN) || (state_ff == ST_ORD_SCAN)) && issue_ok;
         p1_v_ff  <= (state_ff == ST_P_RUN) && issue_ok;
         p2_v_ff  <= p1_v_ff;
         p3_v_ff  <= p2_v_ff;
         p4_v_ff  <= p3_v_ff;
         p5_v_ff  <= p4_v_ff;
         // mark suppressed boxes at the end of the overlap pipe
         if (p5_v_ff && !p5_dis_ff && (cmp_lhs > cmp_rhs)) begin
            sup_ff[p5_j_ff] <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               j_ff <= '0;
               if (pop && item.drop) ovf_ff <= 1'b1;
            end
            ST_INS_SCAN, ST_ORD_SCAN: begin
               if (issue_ok) begin
                  j_ff <= j_ff + 1'b1;
               end
               if (state_in == ST_K_ORD) i_ff <= '0;
            end
            ST_INS_WRITE: begin
               n_ff <= n_ff + 1'b1;
               j_ff <= '0;
            end
            ST_K_ORD: begin
               if (i_ff != n_ff && sup_ff[i_ff[IDX_W-1:0]]) i_ff <= i_ff + 1'b1;
            end
            ST_K_BOX: begin
               if (out_free) begin
                  pend_v_ff <= 1'b1;
                  j_ff      <= i_ff + 1'b1;
               end
            end
            ST_P_RUN: begin
               if (issue_ok) begin
                  j_ff <= j_ff + 1'b1;
               end
               if (state_in == ST_K_ORD) i_ff <= i_ff + 1'b1;
            end
            ST_FLUSH: begin
               if (out_free) begin
                  pend_v_ff <= 1'b0;
                  sup_ff    <= '0;
                  n_ff      <= '0;
                  ovf_ff    <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s1_j_ff <= j_ff[IDX_W-1:0];
      p1_j_ff <= j_ff[IDX_W-1:0];
      p2_j_ff <= p1_j_ff;
      p3_j_ff <= p2_j_ff;
      p4_j_ff <= p3_j_ff;
      p5_j_ff <= p4_j_ff;
      if (pop) begin
         cur_box_ff   <= item.box;
         cur_score_ff <= item.score;
         cur_final_ff <= item.final_box;
         acc_ff       <= '0;
      end
      // count earlier boxes that rank ahead of the new one
      if (state_ff == ST_INS_SCAN && s1_v_ff &&
          !(st_rd[BOX_W +: SCORE_W] < cur_score_ff)) begin
         acc_ff <= acc_ff + 1'b1;
      end
      if (state_ff == ST_K_ORDW) key_idx_ff <= od_rd;
      // take the new keeper, release the previous one
      if (state_ff == ST_K_BOX && out_free) begin
         key_box_ff   <= st_rd[BOX_W-1:0];
         pend_idx_ff  <= key_idx_ff;
         pend_data_ff <= st_rd;
         rsp_data_ff  <= {2'b00, pend_data_ff, pend_idx_ff};
         rsp_last_ff  <= 1'b0;
         rsp_user_ff  <= ovf_ff;
      end
      if (state_ff == ST_FLUSH && out_free) begin
         rsp_data_ff <= {2'b00, pend_data_ff, pend_idx_ff};
         rsp_last_ff <= 1'b1;
         rsp_user_ff <= ovf_ff;
      end
      // overlap pipe: edges and extents
      begin : p_geom
         logic signed [COORD_W-1:0] al, at, ar, ab, bl, bt, br, bb, x1, y1, x2, y2;
         al = $signed(key_box_ff[0 +: COORD_W]);
         at = $signed(key_box_ff[COORD_W +: COORD_W]);
         ar = $signed(key_box_ff[2*COORD_W +: COORD_W]);
         ab = $signed(key_box_ff[3*COORD_W +: COORD_W]);
         bl = $signed(st_rd[0 +: COORD_W]);
         bt = $signed(st_rd[COORD_W +: COORD_W]);
         br = $signed(st_rd[2*COORD_W +: COORD_W]);
         bb = $signed(st_rd[3*COORD_W +: COORD_W]);
         x1 = (al > bl) ? al : bl;
         y1 = (at > bt) ? at : bt;
         x2 = (ar < br) ? ar : br;
         y2 = (ab < bb) ? ab : bb;
         p3_dx_ff  <= DIFF_W'(x2) - DIFF_W'(x1);
         p3_dy_ff  <= DIFF_W'(y2) - DIFF_W'(y1);
         p3_dis_ff <= (x2 < x1) || (y2 < y1);
         p3_wa_ff  <= DIFF_W'(ar) - DIFF_W'(al);
         p3_ha_ff  <= DIFF_W'(ab) - DIFF_W'(at);
         p3_wb_ff  <= DIFF_W'(br) - DIFF_W'(bl);
         p3_hb_ff  <= DIFF_W'(bb) - DIFF_W'(bt);
      end
      // areas
      p4_inter_ff <= p3_dx_ff * p3_dy_ff;
      p4_aa_ff    <= p3_wa_ff * p3_ha_ff;
      p4_ab_ff    <= p3_wb_ff * p3_hb_ff;
      p4_dis_ff   <= p3_dis_ff;
      // union
      p5_uni_ff   <= UNI_W'(p4_aa_ff) + UNI_W'(p4_ab_ff) - UNI_W'(p4_inter_ff);
      p5_inter_ff <= p4_inter_ff;
      p5_dis_ff   <= p4_dis_ff;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_BOXES))
      else $error("box count beyond capacity");
   a_marks_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (sup_ff == '0))
      else $error("suppression marks left over between frames");
   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (!pipe_busy && pend_v_ff))
      else $error("flush with overlap pipe busy or no pending box");
   a_keeper_safe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_RUN && p5_v_ff) |-> (CNT_W'(p5_j_ff) > i_ff))
      else $error("overlap test on a box at or ahead of the keeper");

endmodule

### design/greedy_box_suppression_top.sv
`timescale 1ns / 1ps
// A stored box is ranked by a rank-update sweep over the boxes already stored,
// through the single score memory read port.
// The last box adds an ordering sweep, then each kept box is tested against the later
// boxes through the one shared overlap pipe; a new box waits until the back end is idle.
// Reset (synchronous, active high) empties the store, clears the overflow flag
// and loads the threshold with 29491; memory contents are not cleared.
module greedy_box_suppression_top import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [THR_W-1:0]      csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // box_left, box_top, box_right, box_bottom, score
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // kept_index, kept_left, kept_top, kept_right, kept_bottom, kept_score, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // overflowed
   output logic                  rsp_tuser
);

   logic     f_valid, f_ready, b_valid, b_ready;
   item_type f_item, b_item;

   gbs_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .item_valid(f_valid), .item_ready(f_ready), .item(f_item));

   gbs_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item));

   gbs_back u_back (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser));

endmodule

### tb/greedy_box_suppression_top_tb.sv
`timescale 1ns / 1ps
module greedy_box_suppression_top_tb import gbs_pkg::*; ();

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES = 800;

   typedef struct packed {
      logic [5:0]  index;
      logic [15:0] left;
      logic [15:0] top;
      logic [15:0] right;
      logic [15:0] bottom;
      logic [15:0] score;
      logic        last;
      logic        ovf;
   } kept_box_type;

   // mirror of the frame store and greedy suppression pass
   class nms_scoreboard;
      logic [15:0]  threshold;
      logic [63:0]  frame_boxes[MAX_BOXES];
      logic [15:0]  frame_scores[MAX_BOXES];
      int           frame_count;
      bit           frame_ovf;
      kept_box_type kept_queue[$];
      int           mismatches;

      function new();
         threshold = THR_RESET;
         frame_count = 0;
         frame_ovf = 0;
         mismatches = 0;
      endfunction

      function longint signed sx(logic [15:0] v);
         return longint'($signed(v));
      endfunction

      function bit overlaps(logic [63:0] a, logic [63:0] b);
         longint signed al, at, ar, ab, bl, bt, br, bb, x1, y1, x2, y2, inter, uni;
         al = sx(a[15:0]);  at = sx(a[31:16]); ar = sx(a[47:32]); ab = sx(a[63:48]);
         bl = sx(b[15:0]);  bt = sx(b[31:16]); br = sx(b[47:32]); bb = sx(b[63:48]);
         x1 = al > bl ? al : bl;
         y1 = at > bt ? at : bt;
         x2 = ar < br ? ar : br;
         y2 = ab < bb ? ab : bb;
         if (x2 < x1 || y2 < y1) return 0;
         inter = (x2 - x1) * (y2 - y1);
         uni = (ar - al) * (ab - at) + (br - bl) * (bb - bt) - inter;
         return inter * 65536 > longint'(threshold) * uni;
      endfunction

      // store an accepted box; on the frame's last box, rank and suppress
      function void note_box(logic [79:0] data, logic last);
         int order[MAX_BOXES];
         bit gone[MAX_BOXES];
         int kept[$];
         int j, cur;
         kept_box_type k;
         if (frame_count < MAX_BOXES) begin
            frame_boxes[frame_count] = data[63:0];
            frame_scores[frame_count] = data[79:64];
            frame_count++;
         end else begin
            frame_ovf = 1;
         end
         if (!last) return;
         // stable rank by descending score
         for (int i = 0; i < frame_count; i++) begin
            cur = i;
            j = i;
            while (j > 0 && frame_scores[order[j-1]] < frame_scores[cur]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = cur;
            gone[i] = 0;
         end
         for (int i = 0; i < frame_count; i++) begin
            if (gone[i]) continue;
            kept = {kept, order[i]};
            for (int m = i + 1; m < frame_count; m++)
               if (!gone[m] && overlaps(frame_boxes[order[i]], frame_boxes[order[m]]))
                  gone[m] = 1;
         end
         foreach (kept[n]) begin
            k.index = kept[n][5:0];
            {k.bottom, k.right, k.top, k.left} = frame_boxes[kept[n]];
            k.score = frame_scores[kept[n]];
            k.last = (n == kept.size() - 1);
            k.ovf = frame_ovf;
            kept_queue = {kept_queue, k};
         end
         frame_count = 0;
         frame_ovf = 0;
      endfunction

      function void check_kept(kept_box_type act);
         kept_box_type exp_k;
         if (kept_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", act);
            return;
         end
         exp_k = kept_queue.pop_front();
         if (act !== exp_k) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch: expected idx %0d box %h %h %h %h score %h",
                         " last %b ovf %b,"},
                  exp_k.index, exp_k.left, exp_k.top, exp_k.right, exp_k.bottom,
                  exp_k.score, exp_k.last, exp_k.ovf,
                  " got idx %0d box %h %h %h %h score %h last %b ovf %b",
                  act.index, act.left, act.top, act.right, act.bottom,
                  act.score, act.last, act.ovf);
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  csr_wr_en = 0;
   logic [THR_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tlast = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   nms_scoreboard sb = new();
   bit quiet = 0;
   bit hold_request = 0;
   int cycles = 0;

   greedy_box_suppression_top uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("greedy_box_suppression_top: mismatch");
         $finish;
      end
   end

   // check each result transaction against the oldest kept box
   always @(posedge clock) begin
      kept_box_type act;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act.index = rsp_tdata[5:0];
         act.left = rsp_tdata[21:6];
         act.top = rsp_tdata[37:22];
         act.right = rsp_tdata[53:38];
         act.bottom = rsp_tdata[69:54];
         act.score = rsp_tdata[85:70];
         act.last = rsp_tlast;
         act.ovf = rsp_tuser;
         sb.check_kept(act);
      end
   end

   // receiver: random stall bursts, and one long hold-off on request
   initial begin
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // offer one box and hold it until accepted; called at a falling edge.
   // Valid stays high afterwards until the next box or stop_sending.
   task automatic send_box(logic [15:0] l, t, r, b, s, logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {s, b, r, t, l};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_box({s, b, r, t, l}, last);
      @(negedge clock);
   endtask

   // drop valid after the last offered box; called at a falling edge
   task automatic stop_sending();
      req_tvalid <= 0;
   endtask

   // frame of boxes clustered around a few centers, with some full-range noise
   task automatic send_frame(int n, bit hold_at_end);
      int cx, cy, w, h;
      logic [15:0] l, t;
      for (int i = 0; i < n; i++) begin
         if (i % 4 == 0) begin
            cx = $urandom_range(0, 8000) - 4000;
            cy = $urandom_range(0, 8000) - 4000;
         end
         if ($urandom_range(0, 5) == 0) begin
            l = 16'($urandom);
            t = 16'($urandom);
            if (hold_at_end && i == n - 1) hold_request = 1;
            send_box(l, t, 16'($urandom), 16'($urandom), 16'($urandom), i == n - 1);
         end else begin
            w = $urandom_range(16, 3000);
            h = $urandom_range(16, 3000);
            l = 16'(cx + $urandom_range(0, 300));
            t = 16'(cy + $urandom_range(0, 300));
            if (hold_at_end && i == n - 1) hold_request = 1;
            send_box(l, t, 16'(l + w), 16'(t + h), 16'($urandom), i == n - 1);
         end
      end
   endtask

   // write the threshold once the block has drained
   task automatic set_threshold(logic [15:0] v);
      stop_sending();
      while (sb.kept_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      sb.threshold = v;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: extremes, ties, disjoint, touching, inverted, zero score
      send_box(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 1'b1);
      send_box(16'd0, 16'd0, 16'd160, 16'd160, 16'd1000, 1'b0);
      send_box(16'd0, 16'd0, 16'd160, 16'd160, 16'd1000, 1'b0);
      send_box(16'd1000, 16'd1000, 16'd1100, 16'd1100, 16'd500, 1'b0);
      send_box(16'd160, 16'd0, 16'd320, 16'd160, 16'd2000, 1'b0);
      send_box(16'd300, 16'd300, 16'd100, 16'd100, 16'd3000, 1'b0);
      send_box(16'd0, 16'd0, 16'd16, 16'd16, 16'd0, 1'b1);
      send_box(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'd0, 1'b1);
      send_box(16'd10, 16'd10, 16'd200, 16'd200, 16'd700, 1'b0);
      send_box(16'd20, 16'd20, 16'd210, 16'd210, 16'd700, 1'b1);

      set_threshold(16'd0);
      send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd9, 1'b0);
      send_box(16'd99, 16'd99, 16'd200, 16'd200, 16'd9, 1'b0);
      send_box(16'd100, 16'd0, 16'd200, 16'd100, 16'd8, 1'b1);
      send_frame(8, 0);

      set_threshold(16'hffff);
      send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd50, 1'b0);
      send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd60, 1'b1);
      send_frame(7, 0);

      // overflow frame, then a long hold-off while the next frame is offered
      set_threshold(16'($urandom));
      send_frame(66, 1);
      send_frame(6, 0);

      set_threshold(THR_RESET);
      for (int f = 0; f < 6; f++) send_frame($urandom_range(1, 10), 0);

      set_threshold(16'($urandom_range(8000, 50000)));
      quiet = 1;
      for (int f = 0; f < 4; f++) send_frame($urandom_range(1, 10), 0);
      stop_sending();

      while (sb.kept_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("greedy_box_suppression_top: match");
      else
         $display("greedy_box_suppression_top: mismatch");
      $finish;
   end
endmodule
